// ===== rtl/sobel_gradient_nms_top_macros.svh =====
// assertion macros shared by the checker of the sobel gradient block
// depends on a clock named clk_i and an active-low reset named rst_ni in scope
`ifndef SOBEL_GRADIENT_NMS_TOP_MACROS_SVH
`define SOBEL_GRADIENT_NMS_TOP_MACROS_SVH

// same-cycle implication
`define SGN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sgn_pkg.sv =====
// shared constants, types and helper functions of the sobel gradient block
// no dependencies
package sgn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int CFG_W      = 11;
  localparam int DIM_W      = $clog2(MAX_WIDTH + 1);
  localparam int POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int PIX_AW     = $clog2(4 * MAX_WIDTH + 8);
  localparam int CRD_W      = DIM_W + 1;
  localparam int GRAD_W     = 12;

  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    BIN_HOR     = 2'd0,
    BIN_DIAG_UR = 2'd1,
    BIN_VER     = 2'd2,
    BIN_DIAG_UL = 2'd3
  } bin_e;

  typedef enum logic [1:0] {
    PH_CENTER = 2'd0,
    PH_NBR_A  = 2'd1,
    PH_NBR_B  = 2'd2
  } phase_e;

  typedef struct packed {
    logic   accept;
    logic   start;
    logic   addr;
    logic   read;
    logic   acc;
    logic   square;
    logic   root_init;
    logic   root_step;
    logic   store;
    logic   out_load;
    phase_e phase;
  } sgn_cmd_t;

  typedef struct packed {
    logic emit;
    logic tap_last;
    logic root_done;
    logic out_full;
  } sgn_sts_t;

  function automatic logic [DIM_W-1:0] limit_dim(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    begin
      if (v == '0) begin
        r = {{(DIM_W-1){1'b0}}, 1'b1};
      end else if ({1'b0, v} > {1'b0, max_v}) begin
        r = max_v;
      end else begin
        r = v[DIM_W-1:0];
      end
      return r;
    end
  endfunction

  function automatic logic signed [CRD_W-1:0] clamp_crd(input logic signed [CRD_W-1:0] v,
                                                        input logic [DIM_W-1:0] lim);
    logic signed [CRD_W-1:0] hi;
    begin
      hi = $signed({1'b0, lim} - {{DIM_W{1'b0}}, 1'b1});
      if (v < 0) begin
        return '0;
      end else if (v > hi) begin
        return hi;
      end
      return v;
    end
  endfunction

  // row offset toward the first neighbor of a direction bin
  function automatic logic signed [1:0] nbr_dr(input bin_e b);
    logic signed [1:0] r;
    begin
      case (b)
        BIN_HOR: r = 2'sd0;
        default: r = -2'sd1;
      endcase
      return r;
    end
  endfunction

  // column offset toward the first neighbor of a direction bin
  function automatic logic signed [1:0] nbr_dc(input bin_e b);
    logic signed [1:0] r;
    begin
      case (b)
        BIN_HOR:     r = -2'sd1;
        BIN_DIAG_UR: r = 2'sd1;
        BIN_VER:     r = 2'sd0;
        default:     r = -2'sd1;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/sgn_datapath.sv =====
// datapath of the sobel gradient block: pixel ring, tap walker, sobel
// accumulator, square root unit, suppression and output register; uses sgn_pkg
module sgn_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [sgn_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                     cmd_i,
  input  logic [7:0]               pixel_value_i,
  input  logic                     out_stall_i,
  input  sgn_pkg::sgn_cmd_t        ctrl_i,
  output sgn_pkg::sgn_sts_t        sts_o,
  output logic                     out_valid_o,
  output logic [7:0]               edge_value_o,
  output logic                     frame_end_o
);
  import sgn_pkg::*;

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [DIM_W-1:0] dim_w, dim_h;
  logic [2*DIM_W-1:0] total_full;
  logic [POS_W-1:0] total, lag;
  logic [POS_W-1:0] in_pos_q, out_pos_q;
  logic signed [CRD_W-1:0] out_row_q, out_col_q;
  logic signed [CRD_W-1:0] ctr_row_q, ctr_col_q;
  logic signed [CRD_W-1:0] nbr_row, nbr_col, base_row, base_col;
  logic signed [CRD_W-1:0] tap_row, tap_col;
  logic signed [CRD_W-1:0] dr_ext, dc_ext;
  logic signed [1:0] dr_s, dc_s;
  logic [1:0] tr_q, tc_q;
  logic [CRD_W+DIM_W-1:0] lin_addr;
  logic [PIX_AW-1:0] addr_q;
  logic [7:0] pix_mem [2**PIX_AW];
  logic [7:0] rdata_q;
  logic signed [GRAD_W-1:0] gx_q, gy_q, p1, p2, px, py;
  logic [GRAD_W-2:0] ax, ay, dif;
  logic [GRAD_W-1:0] axy;
  logic [2*GRAD_W-3:0] sq_x_q, sq_y_q, dif_sq_q;
  logic [2*GRAD_W-1:0] sum_sq_q;
  logic gt_q;
  logic [2*GRAD_W-2:0] sum_xy, two_y2;
  logic [15:0] n_q, r_q, bit_q, rb;
  logic [7:0] mag_c_q, mag_a_q, mag_b_q;
  bin_e bin_q, bin_new;
  logic is_pix, pix_write, last_out;

  assign dim_w      = limit_dim(frame_width_q, DIM_W'(MAX_WIDTH));
  assign dim_h      = limit_dim(frame_height_q, DIM_W'(MAX_HEIGHT));
  assign total_full = dim_w * dim_h;
  assign total      = total_full[POS_W-1:0];
  assign lag        = ({{(POS_W-DIM_W){1'b0}}, dim_w} << 1) + POS_W'(2);

  assign is_pix    = (cmd_i == CMD_PIXEL) && (in_pos_q < total);
  assign pix_write = ctrl_i.accept && is_pix;
  assign last_out  = (out_pos_q + POS_W'(1)) == total;

  assign sts_o.emit      = is_pix ? (in_pos_q >= lag) : ((in_pos_q >= total) && (out_pos_q < total));
  assign sts_o.tap_last  = (tr_q == 2'd2) && (tc_q == 2'd2);
  assign sts_o.root_done = (bit_q == '0);
  assign sts_o.out_full  = out_valid_o && out_stall_i;

  // neighbor position along the direction bin
  assign dr_s   = nbr_dr(bin_q);
  assign dc_s   = nbr_dc(bin_q);
  assign dr_ext = {{(CRD_W-2){dr_s[1]}}, dr_s};
  assign dc_ext = {{(CRD_W-2){dc_s[1]}}, dc_s};

  always_comb begin
    case (ctrl_i.phase)
      PH_NBR_A: begin
        base_row = out_row_q + dr_ext;
        base_col = out_col_q + dc_ext;
      end
      PH_NBR_B: begin
        base_row = out_row_q - dr_ext;
        base_col = out_col_q - dc_ext;
      end
      default: begin
        base_row = out_row_q;
        base_col = out_col_q;
      end
    endcase
    nbr_row = clamp_crd(base_row, dim_h);
    nbr_col = clamp_crd(base_col, dim_w);
  end

  assign tap_row  = clamp_crd(ctr_row_q + $signed({{(CRD_W-2){1'b0}}, tr_q}) - CRD_W'(1), dim_h);
  assign tap_col  = clamp_crd(ctr_col_q + $signed({{(CRD_W-2){1'b0}}, tc_q}) - CRD_W'(1), dim_w);
  assign lin_addr = $unsigned(tap_row) * dim_w + (CRD_W+DIM_W)'($unsigned(tap_col));

  // pixel ring, addressed by raster position
  always_ff @(posedge clk_i) begin
    if (pix_write) begin
      pix_mem[in_pos_q[PIX_AW-1:0]] <= pixel_value_i;
    end
    if (ctrl_i.read) begin
      rdata_q <= pix_mem[addr_q];
    end
  end

  // sobel weights as shifts
  assign p1 = GRAD_W'($signed({1'b0, rdata_q}));
  assign p2 = p1 <<< 1;
  assign px = (tr_q == 2'd1) ? p2 : p1;
  assign py = (tc_q == 2'd1) ? p2 : p1;

  assign ax  = gx_q[GRAD_W-1] ? (GRAD_W-1)'(-gx_q) : gx_q[GRAD_W-2:0];
  assign ay  = gy_q[GRAD_W-1] ? (GRAD_W-1)'(-gy_q) : gy_q[GRAD_W-2:0];
  assign axy = {1'b0, ax} + {1'b0, ay};
  assign dif = (ax > ay) ? (ax - ay) : '0;

  assign sum_xy = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign two_y2 = {sq_y_q, 1'b0};
  assign rb     = r_q + bit_q;

  always_comb begin
    if (gx_q == '0) begin
      bin_new = BIN_HOR;
    end else if (gy_q == '0) begin
      bin_new = BIN_VER;
    end else if (sum_sq_q < {1'b0, two_y2}) begin
      bin_new = BIN_VER;
    end else if (gt_q && ({1'b0, dif_sq_q} > two_y2)) begin
      bin_new = BIN_HOR;
    end else if (gx_q[GRAD_W-1] == gy_q[GRAD_W-1]) begin
      bin_new = BIN_DIAG_UL;
    end else begin
      bin_new = BIN_DIAG_UR;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      ctr_row_q <= nbr_row;
      ctr_col_q <= nbr_col;
      gx_q      <= '0;
      gy_q      <= '0;
    end
    if (ctrl_i.addr) begin
      addr_q <= lin_addr[PIX_AW-1:0];
    end
    if (ctrl_i.acc) begin
      if (tc_q == 2'd0) gx_q <= gx_q - px;
      else if (tc_q == 2'd2) gx_q <= gx_q + px;
      if (tr_q == 2'd0) gy_q <= gy_q - py;
      else if (tr_q == 2'd2) gy_q <= gy_q + py;
    end
    if (ctrl_i.square) begin
      sq_x_q   <= ax * ax;
      sq_y_q   <= ay * ay;
      sum_sq_q <= axy * axy;
      dif_sq_q <= dif * dif;
      gt_q     <= ax > ay;
    end
    if (ctrl_i.root_init) begin
      n_q   <= (sum_xy[2*GRAD_W-2:16] != '0) ? 16'hFFFF : sum_xy[15:0];
      r_q   <= '0;
      bit_q <= 16'h4000;
    end
    if (ctrl_i.root_step) begin
      if (n_q >= rb) begin
        n_q <= n_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (ctrl_i.store) begin
      case (ctrl_i.phase)
        PH_CENTER: begin
          mag_c_q <= r_q[7:0];
          bin_q   <= bin_new;
        end
        PH_NBR_A: mag_a_q <= r_q[7:0];
        default:  mag_b_q <= r_q[7:0];
      endcase
    end
    if (ctrl_i.out_load) begin
      edge_value_o <= ((mag_c_q < mag_a_q) || (mag_c_q < mag_b_q)) ? 8'd0 : mag_c_q;
      frame_end_o  <= last_out;
    end
  end

  // control state: configuration, positions, tap counters, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_W'(640);
      frame_height_q <= CFG_W'(480);
      in_pos_q       <= '0;
      out_pos_q      <= '0;
      out_row_q      <= '0;
      out_col_q      <= '0;
      tr_q           <= '0;
      tc_q           <= '0;
      out_valid_o    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) frame_width_q <= cfg_data_i;
        else frame_height_q <= cfg_data_i;
        in_pos_q  <= '0;
        out_pos_q <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end
      if (pix_write) begin
        in_pos_q <= in_pos_q + POS_W'(1);
      end
      if (ctrl_i.start) begin
        tr_q <= '0;
        tc_q <= '0;
      end else if (ctrl_i.acc) begin
        if (tc_q == 2'd2) begin
          tc_q <= '0;
          tr_q <= tr_q + 2'd1;
        end else begin
          tc_q <= tc_q + 2'd1;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (ctrl_i.out_load) begin
        out_valid_o <= 1'b1;
        if (last_out) begin
          out_pos_q <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
          in_pos_q  <= '0;
        end else begin
          out_pos_q <= out_pos_q + POS_W'(1);
          if ($unsigned(out_col_q) == ({1'b0, dim_w} - CRD_W'(1))) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + CRD_W'(1);
          end else begin
            out_col_q <= out_col_q + CRD_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/sgn_ctrl.sv =====
// controller of the sobel gradient block: sequences window reads, square root
// and suppression for the center pixel and its two neighbors; uses sgn_pkg
module sgn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sgn_pkg::sgn_sts_t sts_i,
  output sgn_pkg::sgn_cmd_t ctrl_o
);
  import sgn_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_START  = 10'b0000000010,
    ST_ADDR   = 10'b0000000100,
    ST_READ   = 10'b0000001000,
    ST_ACC    = 10'b0000010000,
    ST_SQUARE = 10'b0000100000,
    ST_RINIT  = 10'b0001000000,
    ST_ROOT   = 10'b0010000000,
    ST_STORE  = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    ctrl_o  = '0;
    ctrl_o.phase = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          phase_d = PH_CENTER;
          if (sts_i.emit) state_d = ST_START;
        end
      end
      ST_START: begin
        ctrl_o.start = 1'b1;
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        ctrl_o.addr = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        ctrl_o.read = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        ctrl_o.acc = 1'b1;
        state_d = sts_i.tap_last ? ST_SQUARE : ST_ADDR;
      end
      ST_SQUARE: begin
        ctrl_o.square = 1'b1;
        state_d = ST_RINIT;
      end
      ST_RINIT: begin
        ctrl_o.root_init = 1'b1;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (sts_i.root_done) state_d = ST_STORE;
        else ctrl_o.root_step = 1'b1;
      end
      ST_STORE: begin
        ctrl_o.store = 1'b1;
        case (phase_q)
          PH_CENTER: begin
            phase_d = PH_NBR_A;
            state_d = ST_START;
          end
          PH_NBR_A: begin
            phase_d = PH_NBR_B;
            state_d = ST_START;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (!sts_i.out_full) begin
          ctrl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_CENTER;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/sobel_gradient_nms_top.sv =====
// top level of the sobel gradient magnitude block with non-maximum suppression
// instantiates sgn_ctrl and sgn_datapath; uses sgn_pkg
//
// usage:
// - input channel (in_valid_i / in_stall_o) carries cmd_i and pixel_value_i;
//   cmd 0 is a gray pixel in raster order, cmd 1 drains one pending result
// - output channel (out_valid_o / out_stall_i) carries edge_value_o and
//   frame_end_o, which marks the last result of a frame
// - frame size comes from the write port: index 0 width, index 1 height;
//   any write restarts the frame, zero reads as one, big values saturate
// - result k of a frame follows the pixel at raster position k + 2*width + 2;
//   after the last pixel, flush items pull out the remaining results
// - an item that makes no result is accepted without the controller leaving idle
// - an item that makes a result is worked on from accept until the result is
//   presented: three sobel windows (center pixel and its two neighbors along
//   the gradient direction) of nine taps, each an address, read and add step
//   on the ring's single read port, then per window an eight-step square root
// - a finished result waits in the output register; the next item is
//   accepted meanwhile, and work only holds when a second result is ready
//   while the receiver still stalls
// - reset empties the output, returns to the start of a frame and loads a
//   640 x 480 frame size; the pixel ring is not cleared (only written pixels
//   of the current frame are ever read)
module sobel_gradient_nms_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [sgn_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [7:0]                pixel_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                edge_value_o,
  output logic                      frame_end_o
);
  import sgn_pkg::*;

  // command and status between sequencer and datapath
  sgn_cmd_t ctrl;
  sgn_sts_t sts;

  sgn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  sgn_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .pixel_value_i (pixel_value_i),
    .out_stall_i   (out_stall_i),
    .ctrl_i        (ctrl),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .edge_value_o  (edge_value_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

// ===== rtl/sgn_checker.sv =====
// port-level assertions for the sobel gradient block, bound to the top level
// depends on sobel_gradient_nms_top_macros.svh
`include "sobel_gradient_nms_top_macros.svh"

module sgn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] edge_value_o,
  input logic       frame_end_o
);

  // a result held by the receiver stays offered
  `SGN_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // a held result keeps its value
  `SGN_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(edge_value_o) && $stable(frame_end_o), "stalled result changed")

  // results are only produced while the input side is busy
  `SGN_ASSERT_IMP(a_rise_busy, $rose(out_valid_o), $past(in_stall_o), "result appeared without work")

  // a new result right after a handoff also comes from a busy cycle
  `SGN_ASSERT_NXT(a_back_to_back, out_valid_o && !out_stall_i, !out_valid_o || $past(in_stall_o), "result loaded outside of work")

endmodule

bind sobel_gradient_nms_top sgn_checker u_sgn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .edge_value_o (edge_value_o),
  .frame_end_o  (frame_end_o)
);

// ===== tb/sobel_gradient_nms_top_test.sv =====
// testbench of sobel_gradient_nms_top: random frames through the pixel channel,
// each result checked against a built-in predictor; uses sgn_pkg for types and codes
module sobel_gradient_nms_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sgn_pkg::*;

  typedef struct {
    logic       cmd;
    logic [7:0] pixel;
  } pix_item_t;

  typedef struct {
    logic [7:0] edge_val;
    logic       frame_end;
  } edge_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 cmd_i;
  logic [7:0]           pixel_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           edge_value_o;
  logic                 frame_end_o;

  sobel_gradient_nms_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .edge_value_o  (edge_value_o),
    .frame_end_o   (frame_end_o)
  );

  // settle margin used around config writes
  localparam int SETTLE_CYCLES = 160;

  pix_item_t    pending_items[$];
  edge_result_t expected_edges[$];
  bit           failed;

  // predictor state: frame size registers, positions and the pixels of the frame
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int               in_pos;
  int               out_pos;
  logic [7:0]       frame_pix[MAX_WIDTH*MAX_HEIGHT];

  // clock, 2 ns period
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // size in use: zero reads as one, large values saturate
  function automatic int frame_dim(input logic [CFG_W-1:0] v, input int max_v);
    if (v == '0) return 1;
    return (int'(v) > max_v) ? max_v : int'(v);
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // 3x3 sobel with replicated borders around (r, c)
  function automatic void sobel_at(input int r, input int c, input int w, input int h,
                                   output int gx, output int gy);
    int p[3][3];
    for (int dr = 0; dr < 3; dr++)
      for (int dc = 0; dc < 3; dc++)
        p[dr][dc] = frame_pix[clip(r + dr - 1, 0, h - 1) * w + clip(c + dc - 1, 0, w - 1)];
    gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
    gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
  endfunction

  // floor of the root, saturated at 255
  function automatic int grad_mag(input int gx, input int gy);
    int s;
    int m;
    s = gx * gx + gy * gy;
    m = 0;
    while (m < 255 && (m + 1) * (m + 1) <= s) m++;
    return m;
  endfunction

  function automatic int mag_clamped(input int r, input int c, input int w, input int h);
    int gx;
    int gy;
    sobel_at(clip(r, 0, h - 1), clip(c, 0, w - 1), w, h, gx, gy);
    return grad_mag(gx, gy);
  endfunction

  // direction bin by exact integer tan(22.5) / tan(67.5) tests
  function automatic bin_e grad_bin(input int gx, input int gy);
    int ax;
    int ay;
    int ay2;
    if (gx == 0) return BIN_HOR;
    if (gy == 0) return BIN_VER;
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    ay2 = 2 * ay * ay;
    if ((ax + ay) * (ax + ay) < ay2) return BIN_VER;
    if (ax > ay && (ax - ay) * (ax - ay) > ay2) return BIN_HOR;
    return ((gx > 0) == (gy > 0)) ? BIN_DIAG_UL : BIN_DIAG_UR;
  endfunction

  // next result of the frame, suppressed when a neighbor along the bin is larger
  function automatic void predict_edge(input int w, input int h, input int total);
    edge_result_t res;
    int   r;
    int   c;
    int   gx;
    int   gy;
    int   t;
    int   dr;
    int   dc;
    bin_e b;
    r = out_pos / w;
    c = out_pos % w;
    sobel_at(r, c, w, h, gx, gy);
    t = grad_mag(gx, gy);
    b = grad_bin(gx, gy);
    case (b)
      BIN_HOR:     begin dr = 0;  dc = -1; end
      BIN_DIAG_UR: begin dr = -1; dc = 1;  end
      BIN_VER:     begin dr = -1; dc = 0;  end
      default:     begin dr = -1; dc = -1; end
    endcase
    res.edge_val = t[7:0];
    if (t < mag_clamped(r + dr, c + dc, w, h)) res.edge_val = '0;
    if (t < mag_clamped(r - dr, c - dc, w, h)) res.edge_val = '0;
    res.frame_end = (out_pos + 1 == total);
    expected_edges.push_back(res);
    out_pos++;
    if (out_pos >= total) begin
      out_pos = 0;
      in_pos  = 0;
    end
  endfunction

  function automatic void predict_item(input logic cmd, input logic [7:0] pixel);
    int w;
    int h;
    int total;
    w = frame_dim(width_reg, MAX_WIDTH);
    h = frame_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    if (cmd == CMD_PIXEL && in_pos < total) begin
      frame_pix[in_pos] = pixel;
      in_pos++;
      if (in_pos - 1 >= 2 * w + 2) predict_edge(w, h, total);
    end else if (in_pos >= total && out_pos < total) begin
      // flush, or a pixel while draining: either drains one result
      predict_edge(w, h, total);
    end
  endfunction

  // driver: bursts of random length with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    pix_item_t it;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      cmd_i         <= CMD_PIXEL;
      pixel_value_i <= '0;
      burst_left    = 0;
      gap_left      = 0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_item(cmd_i, pixel_value_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_valid_i    <= 1'b1;
          cmd_i         <= it.cmd;
          pixel_value_i <= it.pixel;
          if (burst_left == 0) begin
            // long bursts now and then, otherwise short ones
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, 6);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: runs of stall and free cycles of random length
  int stall_left;
  int free_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      free_left   = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall_i <= 1'b0;
    end else begin
      stall_left = $urandom_range(0, 20);
      free_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 600)
                                               : $urandom_range(0, 40);
      out_stall_i <= 1'b0;
    end
  end

  // monitor: each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    edge_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected result edge_value=%0d frame_end=%0b",
                 $time, edge_value_o, frame_end_o);
        failed = 1'b1;
      end else begin
        want = expected_edges.pop_front();
        if (edge_value_o !== want.edge_val) begin
          $display("%0t: edge_value expected %0d actual %0d",
                   $time, want.edge_val, edge_value_o);
          failed = 1'b1;
        end
        if (frame_end_o !== want.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b",
                   $time, want.frame_end, frame_end_o);
          failed = 1'b1;
        end
      end
    end
  end

  // everything sent and received, then let a possible result-less item settle
  task automatic wait_drained();
    wait (pending_items.size() == 0 && !in_valid_i && expected_edges.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both size registers; any write restarts the frame
  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    width_reg  = w;
    height_reg = h;
    in_pos     = 0;
    out_pos    = 0;
  endtask

  // start of a frame only, with early flushes; the next size write abandons it
  task automatic queue_partial(input int count);
    pix_item_t it;
    for (int p = 0; p < count; p++) begin
      it.cmd   = CMD_PIXEL;
      it.pixel = 8'($urandom);
      pending_items.push_back(it);
    end
    for (int k = 0; k < 3; k++) begin
      it.cmd   = CMD_FLUSH;
      it.pixel = 8'($urandom);
      pending_items.push_back(it);
    end
  endtask

  // one frame: pixels by pattern, stray early flushes, then the drain
  // pattern 0 random, 1 vertical step, 2 horizontal step, 3 diagonal, 4 flat level
  task automatic queue_frame(input int pattern, input logic [7:0] level, input bit noisy);
    pix_item_t it;
    int w;
    int h;
    int drain;
    w = frame_dim(width_reg, MAX_WIDTH);
    h = frame_dim(height_reg, MAX_HEIGHT);
    for (int p = 0; p < w * h; p++) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        it.cmd   = CMD_FLUSH;
        it.pixel = 8'($urandom);
        pending_items.push_back(it);
      end
      it.cmd = CMD_PIXEL;
      case (pattern)
        1:       it.pixel = ((p % w) >= w / 2) ? level : 8'd0;
        2:       it.pixel = ((p / w) >= h / 2) ? level : 8'd0;
        3:       it.pixel = ((p % w) + (p / w) >= (w + h) / 2) ? level : 8'd0;
        4:       it.pixel = level;
        default: it.pixel = 8'($urandom);
      endcase
      pending_items.push_back(it);
    end
    drain = (w * h < 2 * w + 2) ? w * h : 2 * w + 2;
    for (int k = 0; k < drain; k++) begin
      // a pixel after the frame is complete drains like a flush
      it.cmd   = (noisy && $urandom_range(0, 4) == 0) ? CMD_PIXEL : CMD_FLUSH;
      it.pixel = 8'($urandom);
      pending_items.push_back(it);
    end
    if (noisy && $urandom_range(0, 2) == 0) begin
      it.cmd   = CMD_FLUSH;
      it.pixel = 8'($urandom);
      pending_items.push_back(it);
    end
  endtask

  initial begin
    int sent;
    failed     = 1'b0;
    width_reg  = 11'd640;
    height_reg = 11'd480;
    in_pos     = 0;
    out_pos    = 0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_WIDTH;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero sizes read as a single pixel frame
    set_frame(11'd0, 11'd0);
    queue_frame(4, 8'hff, 1'b0);
    wait_drained();
    // small frame with strong vertical, horizontal and diagonal edges at the full level
    set_frame(11'd4, 11'd4);
    queue_frame(1, 8'hff, 1'b1);
    queue_frame(2, 8'hff, 1'b0);
    queue_frame(3, 8'hff, 1'b0);
    wait_drained();
    // widest row, started only: no result before the lag, flushes do nothing
    set_frame(11'h7ff, 11'd1);
    queue_partial(40);
    wait_drained();
    // tallest column, started only: results flow, then the frame is abandoned
    set_frame(11'd1, 11'h7ff);
    queue_partial(40);
    wait_drained();

    // random part: mostly small frames with random content
    sent = 0;
    while (sent < 180) begin
      set_frame(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)));
      sent += frame_dim(width_reg, MAX_WIDTH) * frame_dim(height_reg, MAX_HEIGHT);
      queue_frame(($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0,
                  8'($urandom), 1'b1);
      wait_drained();
    end

    wait_drained();
    if (!failed && expected_edges.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard limit well above the slowest legal run
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sobel_gradient_nms_top.f =====
+incdir+rtl
rtl/sgn_pkg.sv
rtl/sgn_datapath.sv
rtl/sgn_ctrl.sv
rtl/sobel_gradient_nms_top.sv
rtl/sgn_checker.sv
tb/sobel_gradient_nms_top_test.sv
